[rtl/core/conv2d_valid_window_filter_unit_assert.svh]
// Assertion macros used by the filter unit FIFO.
`ifndef CONV2D_VALID_WINDOW_FILTER_UNIT_ASSERT_SVH
`define CONV2D_VALID_WINDOW_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CVWF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CVWF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CVWF_ASSERT(lbl, ante, cons)
`define CVWF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/cvwf_pkg.sv]
package cvwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 8;
  localparam int LINE_COLS  = MAX_WIDTH + MAX_KERNEL - 1;
  localparam int HIST_DEPTH = MAX_KERNEL - 1;
  localparam int KSTORE     = MAX_KERNEL * MAX_KERNEL;

  localparam int SMP_W  = 16;
  localparam int COL_W  = $clog2(LINE_COLS);
  localparam int ROW_W  = 14;
  localparam int EW_W   = 12;
  localparam int KIDX_W = $clog2(KSTORE);
  localparam int KPOS_W = $clog2(MAX_KERNEL);
  localparam int OW_W   = 11;
  localparam int OH_W   = 13;
  localparam int K_W    = 4;
  localparam int RES_W  = 24;
  localparam int ACC_W  = 40;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SIZE   = 2'd1;
  localparam logic [1:0] STAT_KERNEL = 2'd2;

  localparam logic [1:0] REG_OUT_WIDTH   = 2'd0;
  localparam logic [1:0] REG_OUT_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE = 2'd2;

  typedef struct packed {
    logic                    is_load;
    logic [KIDX_W-1:0]       idx;
    logic signed [SMP_W-1:0] coef;
    logic signed [SMP_W-1:0] sample;
    logic [COL_W-1:0]        col;
    logic                    full;
    logic                    last;
    logic [1:0]              status;
  } entry_t;

endpackage

[rtl/core/cvwf_fifo.sv]
`include "conv2d_valid_window_filter_unit_assert.svh"

module cvwf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cvwf_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cvwf_pkg::entry_t data_o
);

  cvwf_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `CVWF_ASSERT(a_no_overflow, push_i, cnt_q != 2'd2)
  `CVWF_ASSERT(a_no_underflow, pop_i, cnt_q != 2'd0)
  `CVWF_ASSERT(a_cnt_range, 1'b1, cnt_q != 2'd3)

endmodule

[rtl/core/cvwf_front.sv]
module cvwf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_i,
  input  logic [cvwf_pkg::OW_W-1:0]           out_width_i,
  input  logic [cvwf_pkg::OH_W-1:0]           out_height_i,
  input  logic [cvwf_pkg::K_W-1:0]            kernel_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [cvwf_pkg::KIDX_W-1:0]         coef_index_i,
  input  logic signed [cvwf_pkg::SMP_W-1:0]   coef_value_i,
  input  logic signed [cvwf_pkg::SMP_W-1:0]   sample_i,
  output logic                                push_o,
  output cvwf_pkg::entry_t                    entry_o,
  input  logic                                full_i
);

  logic [cvwf_pkg::COL_W-1:0] col_q, col_d;
  logic [cvwf_pkg::ROW_W-1:0] row_q, row_d;
  logic [cvwf_pkg::EW_W-1:0]  ew, c, kk;
  logic [cvwf_pkg::ROW_W-1:0] eh, kr;
  logic [1:0] status;
  logic full, is_last, adv;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    kk = {{(cvwf_pkg::EW_W-cvwf_pkg::K_W){1'b0}}, kernel_size_i};
    kr = {{(cvwf_pkg::ROW_W-cvwf_pkg::K_W){1'b0}}, kernel_size_i};
    ew = {1'b0, out_width_i} + kk - 1'b1;
    eh = {1'b0, out_height_i} + kr - 1'b1;
    c  = ({1'b0, col_q} >= ew) ? '0 : {1'b0, col_q};
    if (out_width_i == '0 || out_height_i == '0 ||
        {1'b0, out_width_i} > cvwf_pkg::EW_W'(cvwf_pkg::MAX_WIDTH)) begin
      status = cvwf_pkg::STAT_SIZE;
    end else if (kernel_size_i == '0 ||
                 kernel_size_i > cvwf_pkg::K_W'(cvwf_pkg::MAX_KERNEL) ||
                 kk > {1'b0, out_width_i} || kr > {1'b0, out_height_i}) begin
      status = cvwf_pkg::STAT_KERNEL;
    end else begin
      status = cvwf_pkg::STAT_OK;
    end
    full    = (row_q >= kr - 1'b1) && (c >= kk - 1'b1);
    is_last = (row_q >= eh - 1'b1) && (c == ew - 1'b1);
    adv     = push_o && req_type_i && (status == cvwf_pkg::STAT_OK);
    if (c == ew - 1'b1) begin
      col_d = '0;
      row_d = is_last ? '0 : row_q + 1'b1;
    end else begin
      col_d = cvwf_pkg::COL_W'(c + 1'b1);
      row_d = row_q;
    end
    entry_o.is_load = !req_type_i;
    entry_o.idx     = coef_index_i;
    entry_o.coef    = coef_value_i;
    entry_o.sample  = sample_i;
    entry_o.col     = cvwf_pkg::COL_W'(c);
    entry_o.full    = full;
    entry_o.last    = is_last;
    entry_o.status  = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/core/cvwf_back.sv]
module cvwf_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [cvwf_pkg::K_W-1:0]             kernel_size_i,
  input  logic                                 empty_i,
  input  cvwf_pkg::entry_t                     head_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cvwf_pkg::RES_W-1:0]    result_value_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  localparam int MK = cvwf_pkg::MAX_KERNEL;
  localparam int SW = cvwf_pkg::SMP_W;
  localparam int HW = cvwf_pkg::HIST_DEPTH * SW;

  typedef enum logic [2:0] {ST_IDLE, ST_WIN, ST_MAC, ST_FIN, ST_OUT} state_e;

  state_e state_q;
  cvwf_pkg::entry_t e_q;

  logic [HW-1:0] row_mem [cvwf_pkg::LINE_COLS];
  logic [HW-1:0] rdata_q, wdata;
  logic signed [SW-1:0] kmem [cvwf_pkg::KSTORE];
  logic [cvwf_pkg::KSTORE-1:0] kval_q;
  logic signed [SW-1:0] kd_q;
  logic kdv_q;

  logic signed [SW-1:0] win_q [MK][MK];
  logic signed [SW-1:0] win_d [MK][MK];
  logic signed [SW-1:0] scan_q [MK][MK];
  logic signed [SW-1:0] colv [MK];

  logic [cvwf_pkg::KPOS_W-1:0] i_q, j_q;
  logic [cvwf_pkg::KIDX_W-1:0] p_q;
  logic [cvwf_pkg::K_W-1:0]    km1;
  logic signed [SW-1:0]   tap_q;
  logic signed [2*SW-1:0] prod_q;
  logic signed [cvwf_pkg::ACC_W-1:0] acc_q;
  logic signed [cvwf_pkg::ACC_W:0]   rnd;
  logic signed [cvwf_pkg::ACC_W-14:0] qv;
  logic signed [cvwf_pkg::RES_W-1:0] res_q, sat;
  logic v1_q, v2_q, out_free;
  logic last_i, last_j, kwr, rrd, rwr;

  assign km1      = kernel_size_i - 1'b1;
  assign last_i   = ({1'b0, i_q} == km1);
  assign last_j   = ({1'b0, j_q} == km1);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign kwr      = pop_o && head_i.is_load;
  assign rrd      = pop_o && !head_i.is_load;
  assign rwr      = (state_q == ST_WIN);
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    for (int r = 0; r < MK; r++) begin
      if (r < cvwf_pkg::HIST_DEPTH && r < int'(km1)) begin
        colv[r] = rdata_q[r*SW +: SW];
      end else if (r == int'(km1)) begin
        colv[r] = e_q.sample;
      end else begin
        colv[r] = '0;
      end
    end
    for (int r = 0; r < cvwf_pkg::HIST_DEPTH; r++) begin
      wdata[r*SW +: SW] = colv[r+1];
    end
    for (int r = 0; r < MK; r++) begin
      for (int q = 0; q < MK; q++) begin
        if (q < int'(km1) && q < MK - 1) begin
          win_d[r][q] = win_q[r][q+1];
        end else if (q == int'(km1)) begin
          win_d[r][q] = colv[r];
        end else begin
          win_d[r][q] = win_q[r][q];
        end
      end
    end
    rnd = {acc_q[cvwf_pkg::ACC_W-1], acc_q} + (cvwf_pkg::ACC_W+1)'(8192);
    qv  = rnd[cvwf_pkg::ACC_W:14];
    if (qv > (cvwf_pkg::ACC_W-13)'(8388607)) begin
      sat = 24'sh7FFFFF;
    end else if (qv < -(cvwf_pkg::ACC_W-13)'(8388608)) begin
      sat = 24'sh800000;
    end else begin
      sat = qv[cvwf_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rrd) rdata_q <= row_mem[head_i.col];
    if (rwr) row_mem[e_q.col] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (kwr) kmem[head_i.idx] <= head_i.coef;
    kd_q <= kmem[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kval_q <= '0;
      kdv_q  <= 1'b0;
    end else begin
      if (kwr) kval_q[head_i.idx] <= 1'b1;
      kdv_q <= kval_q[p_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_o    <= 1'b0;
      result_value_o <= '0;
      status_o       <= cvwf_pkg::STAT_OK;
      last_o         <= 1'b0;
      e_q            <= '0;
      i_q            <= '0;
      j_q            <= '0;
      p_q            <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      tap_q          <= '0;
      prod_q         <= '0;
      acc_q          <= '0;
      res_q          <= '0;
      for (int r = 0; r < MK; r++) begin
        for (int q = 0; q < MK; q++) begin
          win_q[r][q]  <= '0;
          scan_q[r][q] <= '0;
        end
      end
    end else begin
      if (out_valid_o && out_ready_i && state_q != ST_OUT) out_valid_o <= 1'b0;
      v1_q <= (state_q == ST_MAC);
      v2_q <= v1_q;
      tap_q  <= scan_q[0][0];
      prod_q <= tap_q * (kdv_q ? kd_q : 16'sd0);
      if (v2_q) acc_q <= acc_q + cvwf_pkg::ACC_W'(prod_q);
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            e_q <= head_i;
            if (head_i.is_load) begin
              state_q <= ST_IDLE;
            end else if (head_i.status != cvwf_pkg::STAT_OK) begin
              res_q   <= '0;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_WIN;
            end
          end
        end
        ST_WIN: begin
          win_q <= win_d;
          if (e_q.full) begin
            scan_q  <= win_d;
            i_q     <= '0;
            j_q     <= '0;
            p_q     <= '0;
            acc_q   <= '0;
            state_q <= ST_MAC;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_MAC: begin
          p_q <= p_q + 1'b1;
          if (last_j) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
            for (int r = 0; r < MK - 1; r++) scan_q[r] <= scan_q[r+1];
            if (last_i) state_q <= ST_FIN;
          end else begin
            j_q <= j_q + 1'b1;
            for (int q = 0; q < MK - 1; q++) scan_q[0][q] <= scan_q[0][q+1];
          end
        end
        ST_FIN: begin
          if (!v1_q && !v2_q) begin
            res_q   <= sat;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_o    <= 1'b1;
            result_value_o <= res_q;
            status_o       <= e_q.status;
            last_o         <= (e_q.status == cvwf_pkg::STAT_OK) && e_q.last;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/conv2d_valid_window_filter_unit.sv]
// Streaming 2-D valid-mode correlation over a pre-padded image.
// Input channel (in_valid_i/in_ready_o): req_type_i 0 loads coefficient
// coef_value_i (Q1.14) at coef_index_i; req_type_i 1 delivers one sample of
// the extended image in raster order, (H+K-1) rows of (W+K-1) columns.
// Output channel (out_valid_o/out_ready_i): one item per sample once the
// window is full, or one status item per sample while the size or kernel
// setting is bad; last_o marks the final pixel of a frame.
// Configuration: cfg_we_i writes register cfg_index_i (0 width, 1 height,
// 2 kernel size) and restarts the frame counters; write only while idle.
// Flow: the back end takes a coefficient load in ST_IDLE alone; a sample
// with a good setting passes ST_IDLE and ST_WIN, and one that yields a window
// result then steps the single multiply-accumulate unit through the kernel
// (ST_MAC), drains it (ST_FIN) and offers the result (ST_OUT) before the next pop.
// A two-item queue parts the classifier from the datapath, and an output
// register lets the next item start while a result waits on out_ready_i.
// Reset: width 64, height 64, K 3, kernel all zero, counters at zero;
// line store contents stay undefined until written by the stream.
module conv2d_valid_window_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [cvwf_pkg::OH_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [cvwf_pkg::KIDX_W-1:0]         coef_index_i,
  input  logic signed [cvwf_pkg::SMP_W-1:0]   coef_value_i,
  input  logic signed [cvwf_pkg::SMP_W-1:0]   sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cvwf_pkg::RES_W-1:0]   result_value_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  logic [cvwf_pkg::OW_W-1:0] out_width_q;
  logic [cvwf_pkg::OH_W-1:0] out_height_q;
  logic [cvwf_pkg::K_W-1:0]  kernel_size_q;
  logic cfg_hit, push, full, pop, empty;
  cvwf_pkg::entry_t push_data, head;

  assign cfg_hit = cfg_we_i && (cfg_index_i == cvwf_pkg::REG_OUT_WIDTH ||
                                cfg_index_i == cvwf_pkg::REG_OUT_HEIGHT ||
                                cfg_index_i == cvwf_pkg::REG_KERNEL_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q   <= cvwf_pkg::OW_W'(64);
      out_height_q  <= cvwf_pkg::OH_W'(64);
      kernel_size_q <= cvwf_pkg::K_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cvwf_pkg::REG_OUT_WIDTH:   out_width_q   <= cfg_data_i[cvwf_pkg::OW_W-1:0];
        cvwf_pkg::REG_OUT_HEIGHT:  out_height_q  <= cfg_data_i;
        cvwf_pkg::REG_KERNEL_SIZE: kernel_size_q <= cfg_data_i[cvwf_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  cvwf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_i      (cfg_hit),
    .out_width_i   (out_width_q),
    .out_height_i  (out_height_q),
    .kernel_size_i (kernel_size_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .sample_i      (sample_i),
    .push_o        (push),
    .entry_o       (push_data),
    .full_i        (full)
  );

  cvwf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  cvwf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kernel_size_i  (kernel_size_q),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
